[hw/rtl/nmea_sentence_framer_checker_macros.svh]
// ----------------------------------------------------------------------------
// NMEA sentence framer checker assertion macros
// Shared assertion forms for the framer checker's port-level checks.
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_FRAMER_CHECKER_MACROS_SVH
`define NMEA_SENTENCE_FRAMER_CHECKER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, quiet during reset.
`define NSFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, quiet during reset.
`define NSFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/nsfc_pkg.sv]
// ----------------------------------------------------------------------------
// NMEA sentence framer checker package
// Character codes, limits, result codes and result field layout.
// ----------------------------------------------------------------------------
`default_nettype none

package nsfc_pkg;

    // Line and field limits.
    localparam logic [7:0] LINE_MAX    = 8'd200;
    localparam logic [4:0] FIELD_LIMIT = 5'd20;

    // Characters that steer the framing.
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_G      = 8'h47;

    // Sentence names after the talker letter, first character highest.
    localparam logic [23:0] TAIL_GLL = 24'h474C4C;
    localparam logic [23:0] TAIL_GSA = 24'h475341;
    localparam logic [23:0] TAIL_GGA = 24'h474741;

    // Minimum field counts (exclusive) for each sentence kind.
    localparam logic [4:0] MIN_FIELDS_GLL = 5'd6;
    localparam logic [4:0] MIN_FIELDS_GSA = 5'd17;
    localparam logic [4:0] MIN_FIELDS_GGA = 5'd14;

    // Status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_DOLLAR = 2'd1;
    localparam logic [1:0] STATUS_NO_STAR  = 2'd2;
    localparam logic [1:0] STATUS_BAD_SUM  = 2'd3;

    // Sentence kinds.
    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_GLL   = 2'd1;
    localparam logic [1:0] KIND_GSA   = 2'd2;
    localparam logic [1:0] KIND_GGA   = 2'd3;

    // Result tdata layout, highest field first.
    localparam int OUT_TDATA_W = 32;

    typedef struct packed {
        logic [7:0] line_length;
        logic [7:0] talker_letter;
        logic [4:0] field_count;
        logic [7:0] computed_sum;
        logic [1:0] status;
    } result_t;

endpackage

`default_nettype wire

[hw/rtl/nmea_sentence_framer_checker.sv]
// ----------------------------------------------------------------------------
// NMEA sentence framer checker
// Frames received bytes into NMEA 0183 lines and checks each line on the fly.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock while it is not stalled and,
// for every non-empty line ended by CR or LF, delivers one result item:
// status, XOR checksum, field count, talker letter, sentence kind and line
// length. A byte passes an input register and then a single update stage
// that feeds the result register, which takes the result when the line-end
// byte leaves the input register. The sustained rate is one byte per cycle
// while results are taken. While a result waits, an empty input register
// takes one more byte; the input side then stalls until the result is taken.
`default_nettype none

module nmea_sentence_framer_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Received bytes.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // Line results.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [1:0] status, [9:2] computed_sum,
                                             // [14:10] field_count,
                                             // [22:15] talker_letter,
                                             // [30:23] line_length, [31] zero
    output logic [1:0]       m_axis_tuser    // [1:0] sentence_kind
);

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Line state.
    logic [7:0] line_count_reg,   line_count_next;
    logic [7:0] first_char_reg,   first_char_next;
    logic [7:0] running_xor_reg,  running_xor_next;
    logic       star_seen_reg,    star_seen_next;
    logic [7:0] hex_value_reg,    hex_value_next;
    logic       hex_taking_reg,   hex_taking_next;
    logic       hex_any_reg,      hex_any_next;
    logic [4:0] comma_fields_reg, comma_fields_next;
    logic [7:0] head_chars_reg [6];
    logic [7:0] head_chars_next [6];
    logic [2:0] head_length_reg,  head_length_next;
    logic       head_closed_reg,  head_closed_next;

    // Result register.
    logic                     out_valid_reg;
    nsfc_pkg::result_t        out_data_reg, out_data_next;
    logic [1:0]               out_kind_reg, out_kind_next;
    logic                     produce;

    logic advance;
    logic step;
    logic [7:0] b;
    logic is_end;
    logic restart;

    // Line state after an optional restart, before the byte is taken.
    logic [7:0] base_count;
    logic       base_star;
    logic       base_hex_taking;
    logic       base_closed;
    logic [2:0] base_head_len;
    logic [4:0] base_commas;
    logic [7:0] base_xor;
    logic [7:0] base_hex;
    logic       base_hex_any;
    logic [7:0] base_first;
    logic [7:0] base_head [6];

    logic [4:0] hex_dig;
    logic [1:0] status_c;
    logic [1:0] kind_c;

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 its value.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // True when the first field is "$G?" followed by the given name.
    function automatic logic head_is(input logic [2:0] len,
                                     input logic [7:0] c0,
                                     input logic [7:0] c1,
                                     input logic [7:0] c3,
                                     input logic [7:0] c4,
                                     input logic [7:0] c5,
                                     input logic [23:0] tail);
        return (len == 3'd6) && (c0 == nsfc_pkg::CHAR_DOLLAR) &&
               (c1 == nsfc_pkg::CHAR_G) && (c3 == tail[23:16]) &&
               (c4 == tail[15:8]) && (c5 == tail[7:0]);
    endfunction

    // Handshake: the stage moves when the result register can take a value.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign step          = in_valid_reg && advance;
    assign b             = in_byte_reg;
    assign is_end        = (b == nsfc_pkg::CHAR_CR) || (b == nsfc_pkg::CHAR_LF);
    assign restart       = (b == nsfc_pkg::CHAR_DOLLAR) ||
                           (line_count_reg >= nsfc_pkg::LINE_MAX);
    assign hex_dig       = hex_decode(b);

    // Restart clears the line before the new byte becomes its first byte.
    assign base_count      = restart ? 8'd0 : line_count_reg;
    assign base_star       = restart ? 1'b0 : star_seen_reg;
    assign base_hex_taking = restart ? 1'b0 : hex_taking_reg;
    assign base_closed     = restart ? 1'b0 : head_closed_reg;
    assign base_head_len   = restart ? 3'd0 : head_length_reg;
    assign base_commas     = restart ? 5'd1 : comma_fields_reg;
    assign base_xor        = restart ? 8'd0 : running_xor_reg;
    assign base_hex        = restart ? 8'd0 : hex_value_reg;
    assign base_hex_any    = restart ? 1'b0 : hex_any_reg;
    assign base_first      = restart ? 8'd0 : first_char_reg;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            base_head[i] = restart ? 8'd0 : head_chars_reg[i];
        end
    end

    // Line-end status and sentence kind from the current line state.
    always_comb
    begin
        if (first_char_reg != nsfc_pkg::CHAR_DOLLAR) begin
            status_c = nsfc_pkg::STATUS_NO_DOLLAR;
        end else if (!star_seen_reg) begin
            status_c = nsfc_pkg::STATUS_NO_STAR;
        end else if (!hex_any_reg || (hex_value_reg != running_xor_reg)) begin
            status_c = nsfc_pkg::STATUS_BAD_SUM;
        end else begin
            status_c = nsfc_pkg::STATUS_OK;
        end

        kind_c = nsfc_pkg::KIND_OTHER;
        if (status_c == nsfc_pkg::STATUS_OK) begin
            if (head_is(head_length_reg, head_chars_reg[0], head_chars_reg[1],
                        head_chars_reg[3], head_chars_reg[4], head_chars_reg[5],
                        nsfc_pkg::TAIL_GLL) &&
                (comma_fields_reg > nsfc_pkg::MIN_FIELDS_GLL)) begin
                kind_c = nsfc_pkg::KIND_GLL;
            end else if (head_is(head_length_reg, head_chars_reg[0], head_chars_reg[1],
                                 head_chars_reg[3], head_chars_reg[4], head_chars_reg[5],
                                 nsfc_pkg::TAIL_GSA) &&
                         (comma_fields_reg > nsfc_pkg::MIN_FIELDS_GSA)) begin
                kind_c = nsfc_pkg::KIND_GSA;
            end else if (head_is(head_length_reg, head_chars_reg[0], head_chars_reg[1],
                                 head_chars_reg[3], head_chars_reg[4], head_chars_reg[5],
                                 nsfc_pkg::TAIL_GGA) &&
                         (comma_fields_reg > nsfc_pkg::MIN_FIELDS_GGA)) begin
                kind_c = nsfc_pkg::KIND_GGA;
            end
        end
    end

    // Line state update for one byte.
    always_comb
    begin
        line_count_next   = line_count_reg;
        first_char_next   = first_char_reg;
        running_xor_next  = running_xor_reg;
        star_seen_next    = star_seen_reg;
        hex_value_next    = hex_value_reg;
        hex_taking_next   = hex_taking_reg;
        hex_any_next      = hex_any_reg;
        comma_fields_next = comma_fields_reg;
        head_length_next  = head_length_reg;
        head_closed_next  = head_closed_reg;
        for (int i = 0; i < 6; i++)
        begin
            head_chars_next[i] = head_chars_reg[i];
        end

        produce = 1'b0;
        out_data_next.status        = status_c;
        out_data_next.computed_sum  = running_xor_reg;
        out_data_next.field_count   = comma_fields_reg;
        out_data_next.talker_letter = (head_length_reg >= 3'd3) ? head_chars_reg[2] : 8'd0;
        out_data_next.line_length   = line_count_reg;
        out_kind_next               = kind_c;

        if (step) begin
            if (is_end) begin
                // A non-empty line ends: report it and start a fresh line.
                produce           = (line_count_reg != 8'd0);
                line_count_next   = 8'd0;
                first_char_next   = 8'd0;
                running_xor_next  = 8'd0;
                star_seen_next    = 1'b0;
                hex_value_next    = 8'd0;
                hex_taking_next   = 1'b0;
                hex_any_next      = 1'b0;
                comma_fields_next = 5'd1;
                head_length_next  = 3'd0;
                head_closed_next  = 1'b0;
                for (int i = 0; i < 6; i++)
                begin
                    head_chars_next[i] = 8'd0;
                end
            end else begin
                // Start from the restarted or current line.
                line_count_next   = base_count + 8'd1;
                first_char_next   = base_first;
                running_xor_next  = base_xor;
                star_seen_next    = base_star;
                hex_value_next    = base_hex;
                hex_taking_next   = base_hex_taking;
                hex_any_next      = base_hex_any;
                comma_fields_next = base_commas;
                head_length_next  = base_head_len;
                head_closed_next  = base_closed;
                for (int i = 0; i < 6; i++)
                begin
                    head_chars_next[i] = base_head[i];
                end

                if (base_count == 8'd0) begin
                    // First byte of the line.
                    first_char_next    = b;
                    head_chars_next[0] = b;
                    head_length_next   = 3'd1;
                end else if (!base_star) begin
                    if (b == nsfc_pkg::CHAR_STAR) begin
                        star_seen_next   = 1'b1;
                        hex_taking_next  = 1'b1;
                        head_closed_next = 1'b1;
                    end else begin
                        running_xor_next = base_xor ^ b;
                        if (b == nsfc_pkg::CHAR_COMMA) begin
                            head_closed_next = 1'b1;
                            if (base_commas < (nsfc_pkg::FIELD_LIMIT - 5'd1)) begin
                                comma_fields_next = base_commas + 5'd1;
                            end
                        end else if (!base_closed) begin
                            // Gather the first field, saturating its length.
                            for (int i = 0; i < 6; i++)
                            begin
                                if (base_head_len == 3'(i)) begin
                                    head_chars_next[i] = b;
                                end
                            end
                            if (base_head_len < 3'd7) begin
                                head_length_next = base_head_len + 3'd1;
                            end
                        end
                    end
                end else if (base_hex_taking) begin
                    // Hex digits after the star; the first other byte ends them.
                    if (!hex_dig[4]) begin
                        hex_taking_next = 1'b0;
                    end else begin
                        hex_value_next = {base_hex[3:0], hex_dig[3:0]};
                        hex_any_next   = 1'b1;
                    end
                end
            end
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // Line state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            line_count_reg   <= 8'd0;
            first_char_reg   <= 8'd0;
            running_xor_reg  <= 8'd0;
            star_seen_reg    <= 1'b0;
            hex_value_reg    <= 8'd0;
            hex_taking_reg   <= 1'b0;
            hex_any_reg      <= 1'b0;
            comma_fields_reg <= 5'd1;
            head_length_reg  <= 3'd0;
            head_closed_reg  <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                head_chars_reg[i] <= 8'd0;
            end
        end else begin
            line_count_reg   <= line_count_next;
            first_char_reg   <= first_char_next;
            running_xor_reg  <= running_xor_next;
            star_seen_reg    <= star_seen_next;
            hex_value_reg    <= hex_value_next;
            hex_taking_reg   <= hex_taking_next;
            hex_any_reg      <= hex_any_next;
            comma_fields_reg <= comma_fields_next;
            head_length_reg  <= head_length_next;
            head_closed_reg  <= head_closed_next;
            for (int i = 0; i < 6; i++)
            begin
                head_chars_reg[i] <= head_chars_next[i];
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= produce;
        end
    end

    always_ff @(posedge clk)
    begin
        if (produce) begin
            out_data_reg <= out_data_next;
            out_kind_reg <= out_kind_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = nsfc_pkg::OUT_TDATA_W'(out_data_reg);
    assign m_axis_tuser  = out_kind_reg;

endmodule

`default_nettype wire

[hw/rtl/nsfc_checker.sv]
// ----------------------------------------------------------------------------
// NMEA sentence framer checker port checks
// Assertions on the framer's stream ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nmea_sentence_framer_checker_macros.svh"

module nsfc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,   // [1:0] status, [9:2] computed_sum,
                                            // [14:10] field_count,
                                            // [22:15] talker_letter,
                                            // [30:23] line_length, [31] zero
    input wire logic [1:0]  m_axis_tuser    // [1:0] sentence_kind
);

    logic       rx_seen;
    logic [1:0] status;
    logic [4:0] field_count;
    logic [7:0] line_length;

    assign rx_seen     = s_axis_tvalid && s_axis_tready && (s_axis_tdata != 8'h00);
    assign status      = m_axis_tdata[1:0];
    assign field_count = m_axis_tdata[14:10];
    assign line_length = m_axis_tdata[30:23];

    // A recognized sentence kind needs a passing check, and a GSA kind enough fields.
    `NSFC_ASSERT_NOW(a_kind_needs_ok,
        m_axis_tvalid && (m_axis_tuser != nsfc_pkg::KIND_OTHER) && !rx_seen,
        (status == nsfc_pkg::STATUS_OK) &&
        ((m_axis_tuser != nsfc_pkg::KIND_GSA) || (field_count > nsfc_pkg::MIN_FIELDS_GSA)),
        "sentence kind reported without a passing check or enough fields")

    // Field count stays within its cap and is never zero.
    `NSFC_ASSERT_NOW(a_field_range,
        m_axis_tvalid,
        (field_count != 5'd0) && (field_count < nsfc_pkg::FIELD_LIMIT),
        "field count out of range")

    // A reported line holds at least one and at most the line limit of bytes, and bit 31 is zero.
    `NSFC_ASSERT_NOW(a_length_range,
        m_axis_tvalid,
        (line_length != 8'd0) && (line_length <= nsfc_pkg::LINE_MAX) &&
        (m_axis_tdata[31] == 1'b0),
        "line length out of range")

    // A stalled result holds its value.
    `NSFC_ASSERT_NEXT(a_result_holds,
        m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "result changed while stalled")

endmodule

bind nmea_sentence_framer_checker nsfc_checker u_nsfc_checker (.*);

`default_nettype wire
